### hw/rtl/fiho_pkg.sv
// Shared types and constants for the fade-in / hold / fade-out envelope.
package fiho_pkg;

  localparam int TIME_BITS  = 16;
  localparam int LEVEL_BITS = 16;

  localparam int ELAPSED_W = TIME_BITS + 1;
  localparam int HOLD_W    = TIME_BITS + 1;
  localparam int LEVEL_W   = LEVEL_BITS + 1;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int DIV_CNT_W = $clog2(LEVEL_BITS + 1);

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
  localparam logic [LEVEL_W-1:0]   FULL_LEVEL  = {1'b1, {LEVEL_BITS{1'b0}}};

  typedef enum logic [1:0] {
    PH_IN   = 2'd0,
    PH_HOLD = 2'd1,
    PH_OUT  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    REG_FADE_IN  = 2'd0,
    REG_FADE_OUT = 2'd1,
    REG_HOLD     = 2'd2
  } reg_idx_t;

  typedef enum logic {
    MODE_TICK    = 1'b0,
    MODE_RESTART = 1'b1
  } mode_t;

  typedef struct packed {
    logic                 mode;
    logic [TIME_BITS-1:0] step_time;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [1:0]         phase;
  } result_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] fade_in_time;
    logic [TIME_BITS-1:0] fade_out_time;
    logic [HOLD_W-1:0]    hold_time;
  } cfg_t;

endpackage

### hw/rtl/fiho_regs.sv
// APB-style configuration registers for the envelope.
module fiho_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fiho_pkg::ADDR_W-1:0]  paddr,
  input  logic [fiho_pkg::DATA_W-1:0]  pwdata,
  output logic [fiho_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output fiho_pkg::cfg_t               cfg
);
  import fiho_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_FADE_IN:  cfg.fade_in_time  <= pwdata[TIME_BITS-1:0];
        REG_FADE_OUT: cfg.fade_out_time <= pwdata[TIME_BITS-1:0];
        REG_HOLD:     cfg.hold_time     <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FADE_IN:  prdata = DATA_W'(cfg.fade_in_time);
      REG_FADE_OUT: prdata = DATA_W'(cfg.fade_out_time);
      REG_HOLD:     prdata = DATA_W'(cfg.hold_time);
      default:      prdata = '0;
    endcase
  end

endmodule

### hw/rtl/fiho_div.sv
// Radix-2 restoring divider: quotient = num * 2^LEVEL_BITS / den, num < den.
module fiho_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [fiho_pkg::ELAPSED_W-1:0]  num,
  input  logic [fiho_pkg::TIME_BITS-1:0]  den,
  output logic                            done,
  output logic [fiho_pkg::LEVEL_BITS-1:0] quo
);
  import fiho_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [ELAPSED_W-1:0] rem;
  logic [TIME_BITS-1:0] divisor;
  logic [ELAPSED_W:0]   shifted;
  logic                 fits;

  // remainder stays below den, so the doubled value fits one extra bit
  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= (ELAPSED_W + 1)'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= num;
      divisor <= den;
      quo     <= '0;
      count   <= DIV_CNT_W'(LEVEL_BITS);
    end else if (busy) begin
      if (fits) begin
        rem <= ELAPSED_W'(shifted - (ELAPSED_W + 1)'(divisor));
      end else begin
        rem <= shifted[ELAPSED_W-1:0];
      end
      quo   <= {quo[LEVEL_BITS-2:0], fits};
      count <= count - DIV_CNT_W'(1);
    end
  end

endmodule

### hw/rtl/fade_in_hold_out_envelope.sv
// Fade-in / hold / fade-out envelope generator, top level.
// Each accepted word passes through calc and finish to the output register when no
//   division is needed (restart, phase ends, hold, done); when the level is a ratio,
//   a divide state between them waits for the 16 steps of the shared serial divider.
// Flow: one word at a time; next word taken the cycle after the result
//   is registered, later if the result is stalled.
// Reset (rst, synchronous): phase done, level and elapsed counters zero,
//   registers zero, no result pending.
module fade_in_hold_out_envelope (
  input  logic                           clk,
  input  logic                           rst,
  // input words
  input  logic                           item_valid,
  output logic                           item_stall,
  input  fiho_pkg::item_t                item,
  // result words
  output logic                           result_valid,
  input  logic                           result_stall,
  output fiho_pkg::result_t              result,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fiho_pkg::ADDR_W-1:0]    paddr,
  input  logic [fiho_pkg::DATA_W-1:0]    pwdata,
  output logic [fiho_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import fiho_pkg::*;

  cfg_t cfg;

  fiho_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer and envelope state
  state_t               state, state_next;
  phase_t               phase, phase_next;
  logic [LEVEL_W-1:0]   level, level_next;
  logic [ELAPSED_W-1:0] in_elapsed, in_elapsed_next;
  logic [ELAPSED_W-1:0] hold_elapsed, hold_elapsed_next;
  logic [ELAPSED_W-1:0] out_elapsed, out_elapsed_next;
  logic                 div_is_out, div_is_out_next;
  item_t                cur;

  // Divider hookup
  logic                  div_start;
  logic                  div_done;
  logic [LEVEL_BITS-1:0] div_quo;
  logic [TIME_BITS-1:0]  div_den;

  // Shared saturating adder and compare for the active phase
  logic [ELAPSED_W-1:0] sel_elapsed;
  logic [ELAPSED_W-1:0] sel_dur;
  logic [ELAPSED_W:0]   sum_wide;
  logic [ELAPSED_W-1:0] sum_sat;
  logic                 run_out;
  logic                 hold_timed;
  logic                 load_result;

  fiho_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum_sat),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    unique case (phase)
      PH_IN: begin
        sel_elapsed = in_elapsed;
        sel_dur     = ELAPSED_W'(cfg.fade_in_time);
      end
      PH_HOLD: begin
        sel_elapsed = hold_elapsed;
        sel_dur     = cfg.hold_time;
      end
      default: begin
        sel_elapsed = out_elapsed;
        sel_dur     = ELAPSED_W'(cfg.fade_out_time);
      end
    endcase
  end

  assign sum_wide   = {1'b0, sel_elapsed} + (ELAPSED_W + 1)'(cur.step_time);
  assign sum_sat    = sum_wide[ELAPSED_W] ? ELAPSED_MAX : sum_wide[ELAPSED_W-1:0];
  assign run_out    = sum_sat >= sel_dur;
  // a positive hold runs out once its elapsed count reaches it; zero or negative never ends
  assign hold_timed = (cfg.hold_time != '0) && !cfg.hold_time[HOLD_W-1];
  assign div_den    = (phase == PH_IN) ? cfg.fade_in_time : cfg.fade_out_time;

  assign item_stall  = (state != ST_IDLE);
  assign load_result = (state == ST_FINISH) && !(result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_DONE;
      level        <= '0;
      in_elapsed   <= '0;
      hold_elapsed <= '0;
      out_elapsed  <= '0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      level        <= level_next;
      in_elapsed   <= in_elapsed_next;
      hold_elapsed <= hold_elapsed_next;
      out_elapsed  <= out_elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    div_is_out <= div_is_out_next;
    if (item_valid && !item_stall) begin
      cur <= item;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_next        = state;
    phase_next        = phase;
    level_next        = level;
    in_elapsed_next   = in_elapsed;
    hold_elapsed_next = hold_elapsed;
    out_elapsed_next  = out_elapsed;
    div_is_out_next   = div_is_out;
    div_start         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_CALC;
        end
      end

      ST_CALC: begin
        state_next = ST_FINISH;
        if (cur.mode == MODE_RESTART) begin
          in_elapsed_next   = '0;
          hold_elapsed_next = '0;
          out_elapsed_next  = '0;
          if (cfg.fade_in_time != '0) begin
            phase_next = PH_IN;
            level_next = '0;
          end else if (cfg.hold_time != '0) begin
            phase_next = PH_HOLD;
            level_next = FULL_LEVEL;
          end else if (cfg.fade_out_time != '0) begin
            phase_next = PH_OUT;
            level_next = FULL_LEVEL;
          end else begin
            phase_next = PH_DONE;
            level_next = '0;
          end
        end else begin
          unique case (phase)
            PH_IN: begin
              in_elapsed_next = sum_sat;
              if (run_out) begin
                level_next = FULL_LEVEL;
                if (cfg.hold_time != '0) begin
                  phase_next = PH_HOLD;
                end else if (cfg.fade_out_time == '0) begin
                  phase_next = PH_DONE;
                  level_next = '0;
                end else begin
                  phase_next = PH_OUT;
                end
              end else begin
                div_start       = 1'b1;
                div_is_out_next = 1'b0;
                state_next      = ST_DIV;
              end
            end
            PH_HOLD: begin
              if (hold_timed) begin
                hold_elapsed_next = sum_sat;
                if (run_out) begin
                  if (cfg.fade_out_time == '0) begin
                    phase_next = PH_DONE;
                    level_next = '0;
                  end else begin
                    phase_next = PH_OUT;
                  end
                end
              end
            end
            PH_OUT: begin
              out_elapsed_next = sum_sat;
              if (run_out) begin
                phase_next = PH_DONE;
                level_next = '0;
              end else begin
                div_start       = 1'b1;
                div_is_out_next = 1'b1;
                state_next      = ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end

      ST_DIV: begin
        if (div_done) begin
          level_next = div_is_out ? (FULL_LEVEL - LEVEL_W'(div_quo))
                                  : LEVEL_W'(div_quo);
          state_next = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (load_result) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Output register: holds while stalled, refilled only once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.level <= level;
      result.phase <= phase;
    end
  end

endmodule

### hw/rtl/fiho_checker.sv
// Port-level checks for the envelope, bound to the top level.
module fiho_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_stall,
  input logic                          result_valid,
  input logic                          result_stall,
  input fiho_pkg::result_t             result
);
  import fiho_pkg::*;

  // one word in flight: an accepted word blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("input taken while a word is in flight");

  a_done_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.phase == PH_DONE) |-> (result.level == '0))
    else $error("done phase with nonzero level");

  a_hold_is_full: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.phase == PH_HOLD) |-> (result.level == FULL_LEVEL))
    else $error("hold phase below full level");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.level <= FULL_LEVEL))
    else $error("level above full scale");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind fade_in_hold_out_envelope fiho_checker u_fiho_checker (.*);

### test/testbench.sv
// Testbench for the fade-in / hold / fade-out envelope: live prediction and word-by-word checks.
module testbench;
  import fiho_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 3;
  localparam int SETTLE_CYCLES = 4;     // quiet cycles before touching registers
  localparam int DRAIN_CYCLES  = 25;    // longer than a word with a division takes
  localparam int WATCHDOG_MAX  = 2000;  // idle cycles before giving up
  localparam int HOLDOFF_LEN   = 150;   // long receiver hold-off, in cycles
  localparam int HOLDOFF_AT    = 300;   // results seen before the hold-off
  localparam int RANDOM_SETS   = 22;
  localparam int WORDS_PER_SET = 50;

  localparam logic [ADDR_W-1:0] ADDR_SPARE   = 4'hC;             // unmapped slot
  localparam logic [HOLD_W-1:0] HOLD_FOREVER = {HOLD_W{1'b1}};   // -1

  // receiver stall patterns
  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_HEAVY,
    SINK_PERIODIC
  } sink_mode_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  item_t             item         = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [DATA_W-1:0] pwdata       = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  fade_in_hold_out_envelope i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------
  // Envelope predictor: shadow registers and state, updated per word
  // ---------------------------------------------------------------------
  logic [TIME_BITS-1:0] cfg_fade_in  = '0;
  logic [TIME_BITS-1:0] cfg_fade_out = '0;
  logic [HOLD_W-1:0]    cfg_hold     = '0;

  phase_t               env_phase = PH_DONE;
  logic [ELAPSED_W-1:0] fin_el    = '0;
  logic [ELAPSED_W-1:0] hold_el   = '0;
  logic [ELAPSED_W-1:0] fout_el   = '0;
  logic [LEVEL_W-1:0]   env_level = '0;

  item_t   word_backlog[$];      // words not yet offered to the block
  result_t expected_results[$];  // predicted results, oldest first

  int words_queued = 0;
  int words_in     = 0;
  int words_out    = 0;
  int restarts     = 0;
  int reg_writes   = 0;
  int errors       = 0;
  int phase_hits[4] = '{default: 0};

  // elapsed counters stop at all ones
  function automatic logic [ELAPSED_W-1:0] sat_sum(logic [ELAPSED_W-1:0] a,
                                                   logic [TIME_BITS-1:0] b);
    logic [ELAPSED_W:0] s;
    s = {1'b0, a} + (ELAPSED_W + 1)'(b);
    return (s > ELAPSED_MAX) ? ELAPSED_MAX : s[ELAPSED_W-1:0];
  endfunction

  // truncated num * FULL / den; callers keep num below den
  function automatic logic [LEVEL_W-1:0] frac(logic [ELAPSED_W-1:0] num,
                                              logic [TIME_BITS-1:0] den);
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] q;
    n = 64'(num);
    d = 64'(den);
    q = (n << LEVEL_BITS) / d;
    return q[LEVEL_W-1:0];
  endfunction

  function automatic void to_out_or_done();
    if (cfg_fade_out == '0) begin
      env_level = '0;
      env_phase = PH_DONE;
    end else begin
      env_phase = PH_OUT;
    end
  endfunction

  function automatic result_t envelope_next(item_t w);
    result_t r;
    if (w.mode == MODE_RESTART) begin
      fin_el  = '0;
      hold_el = '0;
      fout_el = '0;
      if (cfg_fade_in != '0) begin
        env_phase = PH_IN;
        env_level = '0;
      end else if (cfg_hold != '0) begin
        env_phase = PH_HOLD;
        env_level = FULL_LEVEL;
      end else if (cfg_fade_out != '0) begin
        env_phase = PH_OUT;
        env_level = FULL_LEVEL;
      end else begin
        env_phase = PH_DONE;
        env_level = '0;
      end
    end else begin
      case (env_phase)
        PH_IN: begin
          fin_el = sat_sum(fin_el, w.step_time);
          if (fin_el >= ELAPSED_W'(cfg_fade_in)) begin
            env_level = FULL_LEVEL;
            if (cfg_hold == '0) to_out_or_done();
            else env_phase = PH_HOLD;
          end else begin
            env_level = frac(fin_el, cfg_fade_in);
          end
        end
        PH_HOLD: begin
          // zero or negative hold never runs out
          if (cfg_hold != '0 && !cfg_hold[HOLD_W-1]) begin
            hold_el = sat_sum(hold_el, w.step_time);
            if (hold_el >= cfg_hold) to_out_or_done();
          end
        end
        PH_OUT: begin
          fout_el = sat_sum(fout_el, w.step_time);
          if (fout_el >= ELAPSED_W'(cfg_fade_out)) begin
            env_level = '0;
            env_phase = PH_DONE;
          end else begin
            env_level = FULL_LEVEL - frac(fout_el, cfg_fade_out);
          end
        end
        default: ;  // done: ticks change nothing
      endcase
    end
    r.level = env_level;
    r.phase = env_phase;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offers backlog words in bursts, predicts on acceptance
  // ---------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_results.push_back(envelope_next(item));
        words_in++;
        if (item.mode == MODE_RESTART) restarts++;
      end
      // payload holds while stalled; otherwise pick the next word or idle
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (word_backlog.size() > 0) begin
          item       <= word_backlog.pop_front();
          item_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each result word, then drives the stall pattern
  // ---------------------------------------------------------------------
  sink_mode_t sink_mode    = SINK_OPEN;
  int         mode_left    = 40;
  int         holdoff_left = 0;
  bit         holdoff_done = 1'b0;

  always @(posedge clk) begin : sink_proc
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word: level %0d phase %0d",
                   $time, result.level, result.phase);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result.level !== want.level) begin
            $display("%0t: level mismatch: expected %0d, actual %0d",
                     $time, want.level, result.level);
            errors++;
          end
          if (result.phase !== want.phase) begin
            $display("%0t: phase mismatch: expected %0d, actual %0d",
                     $time, want.phase, result.phase);
            errors++;
          end
          phase_hits[want.phase]++;
        end
        words_out++;
      end

      // one long hold-off while words keep coming, so the input backs up
      if (holdoff_left > 0) begin
        holdoff_left--;
        result_stall <= 1'b1;
      end else if (!holdoff_done && words_out >= HOLDOFF_AT && word_backlog.size() > 10) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_LEN - 1;
        result_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          sink_mode = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (sink_mode)
          SINK_OPEN:  result_stall <= 1'b0;
          SINK_COIN:  result_stall <= ($urandom_range(0, 1) == 1);
          SINK_HEAVY: result_stall <= ($urandom_range(0, 4) != 0);
          default:    result_stall <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: ends the run if nothing moves for too long
  // ---------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_MAX) begin
      $display("%0t: watchdog: nothing moved for %0d cycles", $time, WATCHDOG_MAX);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Register port and stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic [ADDR_W-1:0] reg_addr(reg_idx_t r);
    return {r, 2'b00};
  endfunction

  // setup cycle, access cycle; the block takes the value at the access edge
  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    if (addr[1:0] == 2'b00) begin
      case (addr[ADDR_W-1:2])
        REG_FADE_IN:  cfg_fade_in  = value[TIME_BITS-1:0];
        REG_FADE_OUT: cfg_fade_out = value[TIME_BITS-1:0];
        REG_HOLD:     cfg_hold     = value[HOLD_W-1:0];
        default: ;    // unmapped slot is ignored
      endcase
    end
  endtask

  // step is cut to the field width
  task automatic queue_word(input mode_t m, input int unsigned step);
    item_t w;
    w.mode      = m;
    w.step_time = TIME_BITS'(step);
    word_backlog.push_back(w);
    words_queued++;
  endtask

  // every word yields one result, so this is the block going idle
  task automatic wait_idle();
    while (words_out < words_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [TIME_BITS-1:0] pick_duration();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 25) return TIME_BITS'(1);
    if (roll < 35) return '1;
    if (roll < 70) return TIME_BITS'($urandom_range(2, 64));
    if (roll < 90) return TIME_BITS'($urandom_range(65, 4000));
    return TIME_BITS'($urandom());
  endfunction

  // mostly a fraction of one of the durations, so envelopes run their course
  function automatic int unsigned pick_step(int unsigned scale);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return 0;
    if (roll < 7) return 32'hFFFF;
    if (roll < 15) return $urandom();
    return $urandom_range(0, scale / 3 + 1);
  endfunction

  task automatic random_set();
    logic [TIME_BITS-1:0] fin;
    logic [TIME_BITS-1:0] fout;
    logic [HOLD_W-1:0]    hold;
    int unsigned          scales[$];
    fin  = pick_duration();
    fout = pick_duration();
    hold = ($urandom_range(0, 6) == 0) ? HOLD_FOREVER : {1'b0, pick_duration()};
    if ($urandom_range(0, 3) == 0) begin
      // retune one register mid-envelope and keep ticking, no restart
      case ($urandom_range(0, 2))
        0:       reg_write(reg_addr(REG_FADE_IN), DATA_W'(fin));
        1:       reg_write(reg_addr(REG_FADE_OUT), DATA_W'(fout));
        default: reg_write(reg_addr(REG_HOLD), DATA_W'(hold));
      endcase
    end else begin
      reg_write(reg_addr(REG_FADE_IN), DATA_W'(fin));
      reg_write(reg_addr(REG_FADE_OUT), DATA_W'(fout));
      reg_write(reg_addr(REG_HOLD), DATA_W'(hold));
      if ($urandom_range(0, 7) == 0) reg_write(ADDR_SPARE, $urandom());
      queue_word(MODE_RESTART, $urandom());
    end
    if (cfg_fade_in != '0) scales.push_back(32'(cfg_fade_in));
    if (cfg_fade_out != '0) scales.push_back(32'(cfg_fade_out));
    if (cfg_hold != '0 && !cfg_hold[HOLD_W-1]) scales.push_back(32'(cfg_hold));
    if (scales.size() == 0) scales.push_back(64);
    for (int n = 0; n < WORDS_PER_SET; n++) begin
      if ($urandom_range(0, 15) == 0)
        queue_word(MODE_RESTART, $urandom());
      else
        queue_word(MODE_TICK, pick_step(scales[$urandom_range(0, scales.size() - 1)]));
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // all durations zero after reset: restart lands in done
    queue_word(MODE_RESTART, '1);
    queue_word(MODE_TICK, '1);
    wait_idle();

    // short full envelope: fade-in end into hold, hold end into fade-out, then done
    reg_write(reg_addr(REG_FADE_IN), 4);
    reg_write(reg_addr(REG_FADE_OUT), 4);
    reg_write(reg_addr(REG_HOLD), 2);
    queue_word(MODE_RESTART, 0);
    queue_word(MODE_TICK, 1);
    queue_word(MODE_TICK, 3);
    queue_word(MODE_TICK, 1);
    queue_word(MODE_TICK, 1);
    queue_word(MODE_TICK, 1);
    queue_word(MODE_TICK, 5);
    queue_word(MODE_TICK, 0);
    wait_idle();

    // negative hold: starts in hold and never leaves it
    reg_write(reg_addr(REG_FADE_IN), 0);
    reg_write(reg_addr(REG_HOLD), DATA_W'(HOLD_FOREVER));
    reg_write(reg_addr(REG_FADE_OUT), '1);
    queue_word(MODE_RESTART, 0);
    queue_word(MODE_TICK, '1);
    wait_idle();

    // longest fade-in with hold and fade-out skipped: straight to done
    reg_write(reg_addr(REG_FADE_IN), '1);
    reg_write(reg_addr(REG_HOLD), 0);
    reg_write(reg_addr(REG_FADE_OUT), 0);
    queue_word(MODE_RESTART, 0);
    queue_word(MODE_TICK, '1);
    wait_idle();

    // fade-out only, longest duration
    reg_write(reg_addr(REG_FADE_IN), 0);
    reg_write(reg_addr(REG_FADE_OUT), '1);
    queue_word(MODE_RESTART, 0);
    queue_word(MODE_TICK, 1);
    queue_word(MODE_TICK, 32'hFFFE);
    wait_idle();

    // fade-in duration cleared mid-phase: ends on the next tick
    reg_write(reg_addr(REG_FADE_IN), 100);
    reg_write(reg_addr(REG_FADE_OUT), 7);
    queue_word(MODE_RESTART, 0);
    queue_word(MODE_TICK, 10);
    wait_idle();
    reg_write(reg_addr(REG_FADE_IN), 0);
    reg_write(ADDR_SPARE, '1);
    queue_word(MODE_TICK, 0);
    queue_word(MODE_TICK, 3);
    queue_word(MODE_TICK, 9);
    wait_idle();

    for (int s = 0; s < RANDOM_SETS; s++) random_set();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d input words (%0d restarts), %0d result words, %0d register writes.",
             words_in, restarts, words_out, reg_writes);
    $display("Results by phase: fade-in %0d, hold %0d, fade-out %0d, done %0d.",
             phase_hits[PH_IN], phase_hits[PH_HOLD], phase_hits[PH_OUT], phase_hits[PH_DONE]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
